@@ rtl/core/ubcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubcd_pkg
// Shared types and constants for the UART bridge command decoder: command
// codes, pending operand kinds, the speed divisor table and the version text.
// ----------------------------------------------------------------------------
package ubcd_pkg;

    // Operand that the next host byte completes
    typedef enum logic [1:0] {
        PEND_NONE   = 2'd0,
        PEND_DIV_HI = 2'd1,
        PEND_DIV_LO = 2'd2,
        PEND_BULK   = 2'd3
    } pend_kind_t;

    // Upper nibble of a host command byte
    localparam logic [3:0] GRP_BASIC  = 4'h0;
    localparam logic [3:0] GRP_BULK   = 4'h1;
    localparam logic [3:0] GRP_PERIPH = 4'h4;
    localparam logic [3:0] GRP_SPEED  = 4'h6;
    localparam logic [3:0] GRP_LINE_A = 4'h8;
    localparam logic [3:0] GRP_LINE_B = 4'h9;

    // Lower nibble of basic commands
    localparam logic [3:0] CMD_EXIT     = 4'h0;
    localparam logic [3:0] CMD_VERSION  = 4'h1;
    localparam logic [3:0] CMD_ECHO_ON  = 4'h2;
    localparam logic [3:0] CMD_ECHO_OFF = 4'h3;
    localparam logic [3:0] CMD_DIV_LOAD = 4'h7;
    localparam logic [3:0] CMD_BRIDGE   = 4'hF;

    localparam logic [7:0] BYTE_ACK  = 8'h01;
    localparam logic [7:0] BYTE_NACK = 8'h00;

    localparam logic [15:0] DIVISOR_RESET = 16'd13332;
    localparam logic [3:0]  SPEED_MAX_IDX = 4'd9;

    // Divisor for each speed index, clamped at the top entry
    function automatic logic [15:0] speed_divisor(input logic [3:0] idx);
        logic [15:0] div;
        case ((idx > SPEED_MAX_IDX) ? SPEED_MAX_IDX : idx)
            4'd0:    div = 16'd13332;
            4'd1:    div = 16'd3332;
            4'd2:    div = 16'd1666;
            4'd3:    div = 16'd832;
            4'd4:    div = 16'd416;
            4'd5:    div = 16'd207;
            4'd6:    div = 16'd127;
            4'd7:    div = 16'd103;
            4'd8:    div = 16'd68;
            default: div = 16'd34;
        endcase
        return div;
    endfunction

    // Version reply text, one character per result
    localparam logic [1:0] VER_LAST_IDX = 2'd3;

    function automatic logic [7:0] version_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h41;  // A
            2'd1:    ch = 8'h52;  // R
            2'd2:    ch = 8'h54;  // T
            default: ch = 8'h31;  // 1
        endcase
        return ch;
    endfunction

endpackage

@@ rtl/core/uart_bridge_command_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_bridge_command_decoder_core
// Decodes host command bytes for a target UART and routes bytes received
// from that UART back to the host, with status of the UART setup per result.
//
// Channel   Direction  Transaction
// s_axis    in         one byte: tuser = source (0 host, 1 target), tdata = byte
// m_axis    out        one result: bytes for host/target, status, tlast = final
//
// An item passes an input register, the decode logic, then the result
// register. Single-result items sustain one per cycle while m_axis is ready;
// the version command holds the result register for its four results, one
// per character. Reset sets the decoder state to its defaults and clears
// both valid registers. Backpressure on m_axis stalls the result register
// and then the input register; s_axis_tready falls only when both are full.
// ----------------------------------------------------------------------------
module uart_bridge_command_decoder_core
    import ubcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data
    input  logic        s_axis_tuser,   // [0] mode

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] host_byte, [15:8] target_byte, [31:16] baud_divisor,
    // [33:32] data_parity, [34] two_stop, [35] rx_inverted, [36] open_drain,
    // [40:37] periph_bits, [41] active, [47:42] zero
    output logic [47:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [0] host_valid, [1] target_valid
    output logic        m_axis_tlast
);

    // Input register
    logic        in_valid_reg;
    logic        in_mode_reg;
    logic [7:0]  in_data_reg;

    // Decoder state
    logic        echo_reg,    echo_next;
    logic        bridge_reg,  bridge_next;
    logic        running_reg, running_next;
    pend_kind_t  pend_reg,    pend_next;
    logic [4:0]  bulk_reg,    bulk_next;
    logic [15:0] div_reg,     div_next;
    logic [3:0]  line_reg,    line_next;
    logic        hiz_reg,     hiz_next;
    logic [3:0]  periph_reg,  periph_next;

    // Result register
    logic        out_valid_reg;
    logic        out_hv_reg;
    logic [7:0]  out_hb_reg;
    logic        out_tv_reg;
    logic [7:0]  out_tb_reg;
    logic        out_last_reg;
    logic        burst_reg;
    logic [1:0]  ver_idx_reg;

    // Decoded result of the item in the input register
    logic        dec_hv;
    logic [7:0]  dec_hb;
    logic        dec_tv;
    logic [7:0]  dec_tb;
    logic        dec_ver;

    logic        out_take;
    logic        out_free;
    logic        move;
    logic [4:0]  bulk_dec;
    logic [1:0]  ver_idx_inc;

    assign out_take      = out_valid_reg && m_axis_tready;
    assign out_free      = !out_valid_reg || (m_axis_tready && out_last_reg);
    assign move          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign bulk_dec      = (bulk_reg != 5'd0) ? bulk_reg - 5'd1 : 5'd0;
    assign ver_idx_inc   = ver_idx_reg + 2'd1;

    // Capture the input transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_mode_reg <= s_axis_tuser;
            in_data_reg <= s_axis_tdata;
        end
    end

    // Decode one byte against the current state
    always_comb
    begin
        echo_next    = echo_reg;
        bridge_next  = bridge_reg;
        running_next = running_reg;
        pend_next    = pend_reg;
        bulk_next    = bulk_reg;
        div_next     = div_reg;
        line_next    = line_reg;
        hiz_next     = hiz_reg;
        periph_next  = periph_reg;
        dec_hv       = 1'b0;
        dec_hb       = BYTE_NACK;
        dec_tv       = 1'b0;
        dec_tb       = 8'h00;
        dec_ver      = 1'b0;

        if (!running_reg)
        begin
            // Stopped: answer nothing
        end
        else if (in_mode_reg)
        begin
            // Target byte: forward when echo or bridge mode is on, unless the UART is off for a divisor load
            if ((echo_reg || bridge_reg) && pend_reg != PEND_DIV_HI
                && pend_reg != PEND_DIV_LO)
            begin
                dec_hv = 1'b1;
                dec_hb = in_data_reg;
            end
        end
        else if (bridge_reg)
        begin
            dec_tv = 1'b1;
            dec_tb = in_data_reg;
        end
        else if (pend_reg == PEND_DIV_HI)
        begin
            div_next  = {in_data_reg, 8'h00};
            pend_next = PEND_DIV_LO;
            dec_hv    = 1'b1;
            dec_hb    = BYTE_ACK;
        end
        else if (pend_reg == PEND_DIV_LO)
        begin
            div_next  = div_reg | {8'h00, in_data_reg};
            pend_next = PEND_NONE;
            dec_hv    = 1'b1;
            dec_hb    = BYTE_ACK;
        end
        else if (pend_reg == PEND_BULK)
        begin
            dec_hv    = 1'b1;
            dec_hb    = BYTE_ACK;
            dec_tv    = 1'b1;
            dec_tb    = in_data_reg;
            bulk_next = bulk_dec;
            if (bulk_dec == 5'd0)
            begin
                pend_next = PEND_NONE;
            end
        end
        else
        begin
            dec_hv = 1'b1;
            dec_hb = BYTE_ACK;
            case (in_data_reg[7:4])
                GRP_BASIC:
                begin
                    case (in_data_reg[3:0])
                        CMD_EXIT:
                        begin
                            running_next = 1'b0;
                            dec_hv       = 1'b0;
                            dec_hb       = BYTE_NACK;
                        end
                        CMD_VERSION:
                        begin
                            dec_hb  = version_char(2'd0);
                            dec_ver = 1'b1;
                        end
                        CMD_ECHO_ON:  echo_next   = 1'b1;
                        CMD_ECHO_OFF: echo_next   = 1'b0;
                        CMD_DIV_LOAD: pend_next   = PEND_DIV_HI;
                        CMD_BRIDGE:   bridge_next = 1'b1;
                        default:      dec_hb      = BYTE_NACK;
                    endcase
                end
                GRP_BULK:
                begin
                    pend_next = PEND_BULK;
                    bulk_next = {1'b0, in_data_reg[3:0]} + 5'd1;
                end
                GRP_PERIPH:
                begin
                    periph_next = in_data_reg[3:0];
                end
                GRP_SPEED:
                begin
                    div_next = speed_divisor(in_data_reg[3:0]);
                end
                GRP_LINE_A, GRP_LINE_B:
                begin
                    line_next = {in_data_reg[0], in_data_reg[1], in_data_reg[3:2]};
                    hiz_next  = !in_data_reg[4];
                end
                default:
                begin
                    dec_hb = BYTE_NACK;
                end
            endcase
        end
    end

    // Commit state when the item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_reg    <= 1'b0;
            bridge_reg  <= 1'b0;
            running_reg <= 1'b1;
            pend_reg    <= PEND_NONE;
            bulk_reg    <= 5'd0;
            div_reg     <= DIVISOR_RESET;
            line_reg    <= 4'd0;
            hiz_reg     <= 1'b1;
            periph_reg  <= 4'd0;
        end
        else if (move)
        begin
            echo_reg    <= echo_next;
            bridge_reg  <= bridge_next;
            running_reg <= running_next;
            pend_reg    <= pend_next;
            bulk_reg    <= bulk_next;
            div_reg     <= div_next;
            line_reg    <= line_next;
            hiz_reg     <= hiz_next;
            periph_reg  <= periph_next;
        end
    end

    // Result register: load a new item, or advance through the version text
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b1;
            burst_reg     <= 1'b0;
            ver_idx_reg   <= 2'd0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
            out_last_reg  <= !dec_ver;
            burst_reg     <= dec_ver;
            ver_idx_reg   <= 2'd0;
        end
        else if (out_take && !out_last_reg)
        begin
            ver_idx_reg  <= ver_idx_inc;
            out_last_reg <= (ver_idx_inc == VER_LAST_IDX);
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
            burst_reg     <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_hv_reg <= dec_hv;
            out_hb_reg <= dec_hb;
            out_tv_reg <= dec_tv;
            out_tb_reg <= dec_tb;
        end
        else if (out_take && !out_last_reg)
        begin
            out_hb_reg <= version_char(ver_idx_inc);
        end
    end

    // Drive the result channel; status comes straight from the state
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_tv_reg, out_hv_reg};
    assign m_axis_tdata  = {6'd0, running_reg, periph_reg, hiz_reg, line_reg,
                            div_reg, out_tb_reg, out_hb_reg};

`ifndef ASSERT_OFF
    a_exit_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |=> !running_reg)
        else $error("decoder left the stopped state without reset");

    a_bridge_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        bridge_reg |=> bridge_reg)
        else $error("bridge mode cleared without reset");

    a_bulk_count: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == PEND_BULK |-> bulk_reg != 5'd0)
        else $error("bulk transfer pending with no bytes left");

    a_multi_is_version: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_last_reg |-> burst_reg)
        else $error("non-final result outside a version reply");

    a_burst_text: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && burst_reg |-> out_hv_reg
            && out_hb_reg == version_char(ver_idx_reg))
        else $error("version reply character out of sequence");
`endif

endmodule
